@@ rtl/unique_with_inverse_and_counts_defines.svh @@
// Assertion macros shared by the unique-with-inverse block.
`ifndef UNIQUE_WITH_INVERSE_AND_COUNTS_DEFINES_SVH
`define UNIQUE_WITH_INVERSE_AND_COUNTS_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define UWIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define UWIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/uwic_pkg.sv @@
// Package with the payload types and sizes of the unique-with-inverse block.
`timescale 1ns / 1ps
package uwic_pkg;
  localparam int MaxElements = 64;
  localparam int ElementBits = 32;
  localparam int AddrW = $clog2(MaxElements);
  localparam int CountW = $clog2(MaxElements + 1);

  typedef struct packed {
    logic [31:0] element_value;
    logic        last_element;
  } in_req_t;

  typedef struct packed {
    logic [5:0]  position;
    logic [5:0]  inverse_index;
    logic        has_unique;
    logic [31:0] unique_value;
    logic [5:0]  first_position;
    logic [6:0]  occurrence_count;
    logic [6:0]  unique_total;
    logic        overflowed;
    logic        last_result;
  } out_req_t;

  // Sort key: flipping the sign bit turns signed order into unsigned order.
  function automatic logic [ElementBits-1:0] order_key(logic [ElementBits-1:0] v,
                                                       logic sgn);
    order_key = v ^ {sgn, {(ElementBits-1){1'b0}}};
  endfunction
endpackage

@@ rtl/uwic_ram.sv @@
// Generic single-port-write, one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module uwic_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/unique_with_inverse_and_counts.sv @@
// Top level of the sorted-unique block with inverse index and counts.
//   channel | ports                          | carries
//   in      | in_valid, in_ready, in_req     | one element per request
//   out     | out_valid, out_ready, out_req  | one result per stored position
//   cfg     | cfg_we, cfg_data               | signed_compare bit
// Loading accepts one element per cycle. After the last element, ranking reads
// element i, then does one pipelined compare per stored element over the single
// read port. Dedupe walks each sorted slot through S_DD_S, S_DD_E and S_DD_W, then
// S_DD_F; each result passes S_EM_R and S_EM_L and waits in S_EM_H until taken.
// Reset is synchronous; it clears state, sign, fill count, overflow and valid only.
// An output stall holds the result register; input waits until the run is emitted.
`timescale 1ns / 1ps
`include "unique_with_inverse_and_counts_defines.svh"
module unique_with_inverse_and_counts (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uwic_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output uwic_pkg::out_req_t out_req,
  input  logic               cfg_we,
  input  logic               cfg_data
);
  localparam int AW = uwic_pkg::AddrW;
  localparam int CW = uwic_pkg::CountW;
  localparam int EB = uwic_pkg::ElementBits;

  // Sequencer states.
  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_RK_I    = 4'd1;
  localparam logic [3:0] S_RK_K    = 4'd2;
  localparam logic [3:0] S_RK_SCAN = 4'd3;
  localparam logic [3:0] S_DD_S    = 4'd4;
  localparam logic [3:0] S_DD_E    = 4'd5;
  localparam logic [3:0] S_DD_W    = 4'd6;
  localparam logic [3:0] S_DD_F    = 4'd7;
  localparam logic [3:0] S_EM_R    = 4'd8;
  localparam logic [3:0] S_EM_L    = 4'd9;
  localparam logic [3:0] S_EM_H    = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic               sgn_r, run_sgn_r;
  logic [CW-1:0]      fill_r, n_r;
  logic               ovf_r;
  logic [AW-1:0]      i_r, j_r, pos_r;
  logic [CW-1:0]      less_r, total_r, cnt_r;
  logic [EB-1:0]      key_i_r, prev_key_r;
  logic               out_valid_r;
  uwic_pkg::out_req_t out_req_r;

  // Element memory, one read port shared by the ranking and dedupe phases.
  logic          e_we;
  logic [AW-1:0] e_wa, e_ra;
  logic [EB-1:0] e_rd;
  uwic_ram #(.Width(EB), .Depth(uwic_pkg::MaxElements)) u_elem (
    .clk, .we(e_we), .waddr(e_wa), .wdata(in_req.element_value[EB-1:0]),
    .raddr(e_ra), .rdata(e_rd));

  // Sorted-slot memory: stable slot -> original position.
  logic          s_we;
  logic [AW-1:0] s_wa, s_rd;
  uwic_ram #(.Width(AW), .Depth(uwic_pkg::MaxElements)) u_slot (
    .clk, .we(s_we), .waddr(s_wa), .wdata(i_r), .raddr(i_r), .rdata(s_rd));

  // Rank per position, and the distinct-value tables.
  logic          r_we;
  logic [AW-1:0] r_wd, r_rd;
  logic          d_we;
  logic [EB-1:0] d_rd;
  logic [AW-1:0] f_rd;
  logic          c_we;
  logic [AW-1:0] c_wa;
  logic [CW-1:0] c_rd;
  uwic_ram #(.Width(AW), .Depth(uwic_pkg::MaxElements)) u_rank (
    .clk, .we(r_we), .waddr(pos_r), .wdata(r_wd), .raddr(i_r), .rdata(r_rd));
  uwic_ram #(.Width(EB), .Depth(uwic_pkg::MaxElements)) u_dval (
    .clk, .we(d_we), .waddr(total_r[AW-1:0]), .wdata(e_rd), .raddr(i_r), .rdata(d_rd));
  uwic_ram #(.Width(AW), .Depth(uwic_pkg::MaxElements)) u_first (
    .clk, .we(d_we), .waddr(total_r[AW-1:0]), .wdata(pos_r), .raddr(i_r), .rdata(f_rd));
  uwic_ram #(.Width(CW), .Depth(uwic_pkg::MaxElements)) u_cnt (
    .clk, .we(c_we), .waddr(c_wa), .wdata(cnt_r), .raddr(i_r), .rdata(c_rd));

  logic          in_acc, out_acc, room;
  logic [EB-1:0] key_j;
  logic          before_i, new_grp, last_i, last_j, has_u;
  logic [CW-1:0] slot_nxt, total_dec;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (state_r == S_LOAD);
  assign room      = (fill_r < CW'(uwic_pkg::MaxElements));
  assign key_j     = uwic_pkg::order_key(e_rd, run_sgn_r);
  assign before_i  = (key_j < key_i_r) || ((key_j == key_i_r) && (j_r < i_r));
  assign slot_nxt  = less_r + CW'(before_i);
  assign new_grp   = (i_r == '0) || (key_j != prev_key_r);
  assign total_dec = total_r - CW'(1);
  assign last_i    = (CW'(i_r) == n_r - CW'(1));
  assign last_j    = (CW'(j_r) == n_r - CW'(1));
  assign has_u     = (CW'(i_r) < total_r);
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // Memory port control and next state.
  always_comb begin
    state_nxt = state_r;
    e_we = in_acc && room;
    e_wa = fill_r[AW-1:0];
    e_ra = i_r;
    s_we = 1'b0;
    s_wa = slot_nxt[AW-1:0];
    r_we = 1'b0;
    r_wd = new_grp ? total_r[AW-1:0] : total_dec[AW-1:0];
    d_we = 1'b0;
    c_we = 1'b0;
    c_wa = total_dec[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && in_req.last_element) state_nxt = S_RK_I;
      end
      S_RK_I: state_nxt = S_RK_K;
      S_RK_K: begin
        e_ra = '0;
        state_nxt = S_RK_SCAN;
      end
      S_RK_SCAN: begin
        e_ra = j_r + AW'(1);
        if (last_j) begin
          s_we = 1'b1;
          state_nxt = last_i ? S_DD_S : S_RK_I;
        end
      end
      S_DD_S: state_nxt = S_DD_E;
      S_DD_E: begin
        e_ra = s_rd;
        state_nxt = S_DD_W;
      end
      S_DD_W: begin
        r_we = 1'b1;
        d_we = new_grp;
        c_we = new_grp && (i_r != '0);
        state_nxt = last_i ? S_DD_F : S_DD_S;
      end
      S_DD_F: begin
        c_we = 1'b1;
        state_nxt = S_EM_R;
      end
      S_EM_R: state_nxt = S_EM_L;
      S_EM_L: state_nxt = S_EM_H;
      S_EM_H: begin
        if (out_acc) state_nxt = last_i ? S_LOAD : S_EM_R;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Sequencer registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      sgn_r <= 1'b0;
      fill_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sgn_r <= cfg_data;
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (room) fill_r <= fill_r + CW'(1);
            else ovf_r <= 1'b1;
            if (in_req.last_element) begin
              run_sgn_r <= cfg_we ? cfg_data : sgn_r;
              n_r <= room ? fill_r + CW'(1) : fill_r;
              i_r <= '0;
            end
          end
        end
        S_RK_K: begin
          key_i_r <= key_j;
          less_r <= '0;
          j_r <= '0;
        end
        S_RK_SCAN: begin
          less_r <= slot_nxt;
          j_r <= j_r + AW'(1);
          if (last_j) begin
            i_r <= last_i ? '0 : i_r + AW'(1);
            total_r <= '0;
          end
        end
        S_DD_E: pos_r <= s_rd;
        S_DD_W: begin
          prev_key_r <= key_j;
          if (new_grp) begin
            total_r <= total_r + CW'(1);
            cnt_r <= CW'(1);
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
          i_r <= last_i ? '0 : i_r + AW'(1);
        end
        S_EM_L: begin
          out_valid_r <= 1'b1;
          out_req_r.position <= i_r;
          out_req_r.inverse_index <= r_rd;
          out_req_r.has_unique <= has_u;
          out_req_r.unique_value <= has_u ? 32'(d_rd) : '0;
          out_req_r.first_position <= has_u ? f_rd : '0;
          out_req_r.occurrence_count <= has_u ? c_rd : '0;
          out_req_r.unique_total <= total_r;
          out_req_r.overflowed <= ovf_r;
          out_req_r.last_result <= last_i;
        end
        S_EM_H: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (last_i) begin
              fill_r <= '0;
              ovf_r <= 1'b0;
            end else begin
              i_r <= i_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Protocol and range checks.
  `UWIC_ASSERT_IMPL(a_in_blocked, out_valid, !in_ready, "input open while a result waits")
  `UWIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_req), "result moved")
  `UWIC_ASSERT_IMPL(a_rank_range, out_valid, 7'(out_req.inverse_index) < out_req.unique_total, "rank")
endmodule
